@@ sv/gaussian_linear_moment_mac_macros.svh @@
// Assertion macros for the moment MAC modules; glmm_fifo includes them.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef GAUSSIAN_LINEAR_MOMENT_MAC_MACROS_SVH
`define GAUSSIAN_LINEAR_MOMENT_MAC_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define GLMM_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define GLMM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/glmm_pkg.sv @@
// Package for the Gaussian moment MAC: formats, widths, register codes and
// the types passed between the front end, the term queue and the back end.
`default_nettype none
package glmm_pkg;
	localparam int FRAC_BITS = 12;
	localparam int IN_W      = 16;
	localparam int MT_W      = 2 * IN_W;
	localparam int SQ_W      = 2 * IN_W - 1;
	localparam int PF_W      = IN_W + SQ_W;
	localparam int P_W       = PF_W - FRAC_BITS;
	localparam int VT_W      = ((P_W > MT_W) ? P_W : MT_W) + 2;
	localparam int ACC_W     = 48;
	localparam int VAR_W     = 47;
	localparam int VS_W      = ((VT_W > VAR_W) ? VT_W : VAR_W) + 1;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);
	localparam int QCW       = $clog2(QDEPTH + 1);
	localparam int CFG_IW    = 2;

	localparam logic [CFG_IW-1:0] CFG_BIAS_MEAN = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_BIAS_VAR  = 2'd1;

	typedef struct packed {
		logic signed [MT_W-1:0] mean_term;
		logic [VT_W-1:0]        var_term;
		logic                   last;
	} term_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           empty;
	} fifo_stat_t;

	typedef struct packed {
		logic signed [IN_W-1:0] bmean;
		logic [IN_W-1:0]        bvar;
	} bias_t;
endpackage
`default_nettype wire

@@ sv/gaussian_linear_moment_mac.sv @@
// A result passes stages s1, s2, the term queue, the fin and output registers.
// Throughput: one item per cycle, set by the multiplier pipeline and the mean
// and variance adds of the back end; a stalled output backs up through the queue.
// Reset: asynchronous, active low; clears accumulators, flags, queue and biases.
// Depends on glmm_pkg, glmm_front, glmm_fifo and glmm_back.
`default_nettype none
module gaussian_linear_moment_mac import glmm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IW-1:0]       cfg_index,
	input  logic [IN_W-1:0]         cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [IN_W-1:0]  h_mean,
	input  logic [IN_W-1:0]         h_var,
	input  logic signed [IN_W-1:0]  w_mean,
	input  logic [IN_W-1:0]         w_var,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [ACC_W-1:0] z_mean,
	output logic [VAR_W-1:0]        z_var,
	output logic                    saturated
);
	bias_t      bias_q;
	fifo_stat_t stat;
	term_t      push_term;
	term_t      head_term;
	logic       push;
	logic       pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BIAS_MEAN: bias_q.bmean <= cfg_data;
				CFG_BIAS_VAR:  bias_q.bvar  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	glmm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.h_mean   (h_mean),
		.h_var    (h_var),
		.w_mean   (w_mean),
		.w_var    (w_var),
		.last     (last),
		.stat     (stat),
		.push     (push),
		.term     (push_term)
	);

	glmm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_term),
		.pop    (pop),
		.rdata  (head_term),
		.stat   (stat)
	);

	glmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.ent       (head_term),
		.pop       (pop),
		.bias      (bias_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.z_mean    (z_mean),
		.z_var     (z_var),
		.saturated (saturated)
	);
endmodule
`default_nettype wire

@@ sv/glmm_fifo.sv @@
// Short register queue of product terms between front end and back end.
// Depends on glmm_pkg and the shared assertion macros.
`default_nettype none
`include "gaussian_linear_moment_mac_macros.svh"
module glmm_fifo import glmm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  term_t      wdata,
	input  logic       pop,
	output term_t      rdata,
	output fifo_stat_t stat
);
	term_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);

	`GLMM_ASSERT_IMPL(a_no_overflow, push && !pop, count_q != QCW'(QDEPTH), "queue overflow")
	`GLMM_ASSERT_IMPL(a_no_underflow, pop, count_q != '0, "queue underflow")
	`GLMM_ASSERT_NEXT(a_count_hold, push && pop, count_q == $past(count_q), "queue count drift")
endmodule
`default_nettype wire

@@ sv/glmm_front.sv @@
// Front end: accepts items against queue credit and forms the product terms
// in a two-stage multiplier pipeline. Depends on glmm_pkg.
`default_nettype none
module glmm_front import glmm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [IN_W-1:0] h_mean,
	input  logic [IN_W-1:0]        h_var,
	input  logic signed [IN_W-1:0] w_mean,
	input  logic [IN_W-1:0]        w_var,
	input  logic                   last,
	input  fifo_stat_t             stat,
	output logic                   push,
	output term_t                  term
);
	logic                   valid_s1;
	logic                   valid_s2;
	logic signed [MT_W-1:0] mm_s1;
	logic [MT_W-1:0]        vv_s1;
	logic [SQ_W-1:0]        wm2_s1;
	logic [SQ_W-1:0]        hm2_s1;
	logic [IN_W-1:0]        hv_s1;
	logic [IN_W-1:0]        wv_s1;
	logic                   last_s1;
	logic signed [MT_W-1:0] mm_s2;
	logic [MT_W-1:0]        vv_s2;
	logic [P_W-1:0]         p1_s2;
	logic [P_W-1:0]         p2_s2;
	logic                   last_s2;
	logic signed [MT_W-1:0] wm_sq;
	logic signed [MT_W-1:0] hm_sq;
	logic [PF_W-1:0]        prod1;
	logic [PF_W-1:0]        prod2;
	logic [QCW-1:0]         occupancy;
	logic                   accept;

	assign occupancy = stat.count + QCW'(valid_s1) + QCW'(valid_s2);
	assign in_ready  = (occupancy < QCW'(QDEPTH));
	assign accept    = in_valid && in_ready;

	assign wm_sq = w_mean * w_mean;
	assign hm_sq = h_mean * h_mean;
	assign prod1 = PF_W'(hv_s1) * PF_W'(wm2_s1);
	assign prod2 = PF_W'(wv_s1) * PF_W'(hm2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mm_s1   <= h_mean * w_mean;
		vv_s1   <= h_var * w_var;
		wm2_s1  <= wm_sq[SQ_W-1:0];
		hm2_s1  <= hm_sq[SQ_W-1:0];
		hv_s1   <= h_var;
		wv_s1   <= w_var;
		last_s1 <= last;
		mm_s2   <= mm_s1;
		vv_s2   <= vv_s1;
		p1_s2   <= prod1[PF_W-1:FRAC_BITS];
		p2_s2   <= prod2[PF_W-1:FRAC_BITS];
		last_s2 <= last_s1;
	end

	assign push           = valid_s2;
	assign term.mean_term = mm_s2;
	assign term.var_term  = VT_W'(vv_s2) + VT_W'(p1_s2) + VT_W'(p2_s2);
	assign term.last      = last_s2;
endmodule
`default_nettype wire

@@ sv/glmm_back.sv @@
// Back end: saturating mean and variance accumulators, bias stage and the
// output register. Depends on glmm_pkg.
`default_nettype none
module glmm_back import glmm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fifo_stat_t              stat,
	input  term_t                   ent,
	output logic                    pop,
	input  bias_t                   bias,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [ACC_W-1:0] z_mean,
	output logic [VAR_W-1:0]        z_var,
	output logic                    saturated
);
	localparam logic signed [ACC_W-1:0] MEAN_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] MEAN_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [VAR_W-1:0]        VAR_MAX  = {VAR_W{1'b1}};

	logic signed [ACC_W-1:0] mean_acc_q;
	logic [VAR_W-1:0]        var_acc_q;
	logic                    sat_seen_q;
	logic                    fin_valid_q;
	logic signed [ACC_W-1:0] fin_mean_q;
	logic [VAR_W-1:0]        fin_var_q;
	logic                    fin_sat_q;
	logic                    out_valid_q;
	logic signed [ACC_W-1:0] z_mean_q;
	logic [VAR_W-1:0]        z_var_q;
	logic                    sat_q;
	logic                    fin_move;
	logic                    fin_free;
	logic [ACC_W:0]          msum;
	logic [VS_W-1:0]         vsum;
	logic signed [ACC_W-1:0] mean_next;
	logic [VAR_W-1:0]        var_next;
	logic                    sat_next;
	logic [ACC_W:0]          bsum;
	logic [VAR_W:0]          bvsum;
	logic signed [ACC_W-1:0] zm;
	logic [VAR_W-1:0]        zv;
	logic                    zsat;

	assign fin_move = fin_valid_q && (!out_valid_q || out_ready);
	assign fin_free = !fin_valid_q || fin_move;
	assign pop      = !stat.empty && (!ent.last || fin_free);

	assign msum = {mean_acc_q[ACC_W-1], mean_acc_q}
		+ {{(ACC_W+1-MT_W){ent.mean_term[MT_W-1]}}, ent.mean_term};
	assign vsum = VS_W'(var_acc_q) + VS_W'(ent.var_term);

	always_comb begin
		sat_next = sat_seen_q;
		if (msum[ACC_W] != msum[ACC_W-1]) begin
			mean_next = msum[ACC_W] ? MEAN_MIN : MEAN_MAX;
			sat_next  = 1'b1;
		end else begin
			mean_next = msum[ACC_W-1:0];
		end
		if (vsum[VS_W-1:VAR_W] != '0) begin
			var_next = VAR_MAX;
			sat_next = 1'b1;
		end else begin
			var_next = vsum[VAR_W-1:0];
		end
	end

	assign bsum = {fin_mean_q[ACC_W-1], fin_mean_q}
		+ ({{(ACC_W+1-IN_W){bias.bmean[IN_W-1]}}, bias.bmean} << FRAC_BITS);
	assign bvsum = {1'b0, fin_var_q} + ((VAR_W+1)'(bias.bvar) << FRAC_BITS);

	always_comb begin
		zsat = fin_sat_q;
		if (bsum[ACC_W] != bsum[ACC_W-1]) begin
			zm   = bsum[ACC_W] ? MEAN_MIN : MEAN_MAX;
			zsat = 1'b1;
		end else begin
			zm = bsum[ACC_W-1:0];
		end
		if (bvsum[VAR_W]) begin
			zv   = VAR_MAX;
			zsat = 1'b1;
		end else begin
			zv = bvsum[VAR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_acc_q  <= '0;
			var_acc_q   <= '0;
			sat_seen_q  <= 1'b0;
			fin_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (ent.last) begin
					mean_acc_q <= '0;
					var_acc_q  <= '0;
					sat_seen_q <= 1'b0;
				end else begin
					mean_acc_q <= mean_next;
					var_acc_q  <= var_next;
					sat_seen_q <= sat_next;
				end
			end
			if (pop && ent.last) begin
				fin_valid_q <= 1'b1;
			end else if (fin_move) begin
				fin_valid_q <= 1'b0;
			end
			if (fin_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && ent.last) begin
			fin_mean_q <= mean_next;
			fin_var_q  <= var_next;
			fin_sat_q  <= sat_next;
		end
		if (fin_move) begin
			z_mean_q <= zm;
			z_var_q  <= zv;
			sat_q    <= zsat;
		end
	end

	assign out_valid = out_valid_q;
	assign z_mean    = z_mean_q;
	assign z_var     = z_var_q;
	assign saturated = sat_q;
endmodule
`default_nettype wire
